FILE: hdl/mldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldc_pkg
// Shared constants for the meter line deframer with checksum check.
// ----------------------------------------------------------------------------
package mldc_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam logic [7:0] CR_CODE    = 8'h0D;
    localparam logic [7:0] SPACE_CODE = 8'h20;

    localparam logic [1:0] STATUS_DATA   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

endpackage

FILE: hdl/mldc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mldc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/meter_line_deframer_checksum_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_line_deframer_checksum_check
// Collects meter line bytes, checks the trailing checksum at carriage return
// and streams verified characters, an empty-line marker or a reject word.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  s_      | s_valid s_ready s_rx_byte                     | in, raw bytes
//  m_      | m_valid m_ready m_line_char m_last_of_line    | out, results
//          | m_line_status                                 |
//
// A byte other than carriage return is accepted without leaving the idle state.
// A carriage return on a line of s stored characters (s >= 2) starts a checksum
// scan through the line store read port, then a settle and a verdict step, then
// one read and one output load per emitted character; output stalls hold the load.
// A line with fewer than 2 characters is rejected without a scan.
// s_ready is low from carriage return until the last word is loaded.
// aresetn is synchronous and active low; the line store needs no clearing.
// ----------------------------------------------------------------------------
module meter_line_deframer_checksum_check
    import mldc_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_line_char,
    output logic       m_last_of_line,
    output logic [1:0] m_line_status
);

    localparam int W = $clog2(LINE_BYTES);
    localparam logic [W-1:0] SLOTS = W'(LINE_BYTES - 2);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_SETTLE   = 6'b000100,
        ST_VERDICT  = 6'b001000,
        ST_EMIT_RD  = 6'b010000,
        ST_EMIT_OUT = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [W-1:0] fill_reg, fill_next;
    logic [W-1:0] len_reg, len_next;
    logic [W-1:0] idx_reg, idx_next;
    logic [W-1:0] pidx_reg;
    logic         pend_reg;
    logic [5:0]   sum_reg, sum_next;
    logic         spc_ok_reg, spc_ok_next;
    logic [7:0]   ck_reg, ck_next;

    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_char_reg, m_char_next;
    logic       m_last_reg, m_last_next;
    logic [1:0] m_status_reg, m_status_next;

    logic         ram_we;
    logic         ram_re;
    logic [W-1:0] ram_raddr;
    logic [7:0]   ram_rdata;
    logic         in_acc;
    logic         out_free;
    logic         good;

    mldc_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(fill_reg),
        .wdata(s_rx_byte),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign good     = spc_ok_reg && (ck_reg == (SPACE_CODE + {2'b00, sum_reg}));

    assign ram_we    = in_acc && (s_rx_byte >= SPACE_CODE) && (fill_reg < SLOTS);
    assign ram_re    = (state_reg == ST_SCAN) || (state_reg == ST_EMIT_RD);
    assign ram_raddr = idx_reg;

    assign m_valid        = m_valid_reg;
    assign m_line_char    = m_char_reg;
    assign m_last_of_line = m_last_reg;
    assign m_line_status  = m_status_reg;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        spc_ok_next   = spc_ok_reg;
        ck_next       = ck_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        if (pend_reg) begin
            if (pidx_reg < (len_reg - W'(2))) begin
                sum_next = sum_reg + ram_rdata[5:0];
            end
            if (pidx_reg == (len_reg - W'(2))) begin
                spc_ok_next = (ram_rdata == SPACE_CODE);
            end
            if (pidx_reg == (len_reg - W'(1))) begin
                ck_next = ram_rdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_rx_byte == CR_CODE) begin
                        len_next    = fill_reg;
                        fill_next   = '0;
                        idx_next    = '0;
                        sum_next    = '0;
                        spc_ok_next = 1'b0;
                        ck_next     = '0;
                        state_next  = (fill_reg < W'(2)) ? ST_VERDICT : ST_SCAN;
                    end else if (ram_we) begin
                        fill_next = fill_reg + W'(1);
                    end
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + W'(1);
                if (idx_reg == (len_reg - W'(1))) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = ST_VERDICT;
            end
            ST_VERDICT: begin
                idx_next = '0;
                if (!good) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_char_next   = '0;
                        m_last_next   = 1'b1;
                        m_status_next = STATUS_REJECT;
                        state_next    = ST_IDLE;
                    end
                end else if (len_reg == W'(2)) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_char_next   = '0;
                        m_last_next   = 1'b1;
                        m_status_next = STATUS_EMPTY;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_char_next   = ram_rdata[6:0];
                    m_last_next   = (idx_reg == (len_reg - W'(3)));
                    m_status_next = STATUS_DATA;
                    idx_next      = idx_reg + W'(1);
                    state_next    = (idx_reg == (len_reg - W'(3))) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= (state_reg == ST_SCAN);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        pidx_reg     <= idx_reg;
        sum_reg      <= sum_next;
        spc_ok_reg   <= spc_ok_next;
        ck_reg       <= ck_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

endmodule

FILE: hdl/mldc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldc_checker
// Port-level checks for the meter line deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mldc_checker
    import mldc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_line_char,
    input logic       m_last_of_line,
    input logic [1:0] m_line_status
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_char)
            && $stable(m_last_of_line) && $stable(m_line_status))
        else $error("stalled result word changed");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_line_status != STATUS_DATA) |-> m_last_of_line && (m_line_char == 7'd0))
        else $error("marker or reject word not a lone last word");

    a_plain_byte_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_rx_byte != CR_CODE) && !m_valid |=> !m_valid)
        else $error("result word without line end");

endmodule

bind meter_line_deframer_checksum_check mldc_checker u_mldc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_rx_byte     (s_rx_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_line_char   (m_line_char),
    .m_last_of_line(m_last_of_line),
    .m_line_status (m_line_status)
);

FILE: sim/meter_line_deframer_checksum_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_line_deframer_checksum_check_test
// Drives framed and broken meter lines, control bytes and raw noise into the
// deframer with random gaps and output stalls. Each accepted byte updates a
// line model that predicts the verified characters, empty-line markers and
// reject words; the result words are checked in order against it.
// ----------------------------------------------------------------------------
module meter_line_deframer_checksum_check_test;
    import mldc_pkg::*;

    localparam int LINE_CAP        = LINE_BYTES_DEF - 2;
    localparam int RANDOM_BYTES    = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_NO_SPACE,
        FRAME_HIGH_SUM,
        FRAME_NO_TAIL
    } frame_fault_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic [1:0] status;
    } line_word_t;

    class line_checksum_board;
        logic [7:0]  line_buf [LINE_BYTES_DEF];
        int unsigned fill = 0;
        int unsigned errors = 0;
        line_word_t  pending_words [$];

        function void note_rx_byte(logic [7:0] b);
            logic [5:0] sum;
            logic [7:0] want_sum;
            bit         good;
            line_word_t w;
            if (b == CR_CODE) begin
                good = 1'b0;
                if (fill >= 2) begin
                    sum = '0;
                    for (int i = 0; i + 2 < fill; i++) sum += line_buf[i][5:0];
                    want_sum = {2'b00, sum} + SPACE_CODE;
                    good = (line_buf[fill - 2] == SPACE_CODE) && (line_buf[fill - 1] == want_sum);
                end
                if (!good) begin
                    w = '{ch: 7'd0, last: 1'b1, status: STATUS_REJECT};
                    pending_words.push_back(w);
                end else if (fill == 2) begin
                    w = '{ch: 7'd0, last: 1'b1, status: STATUS_EMPTY};
                    pending_words.push_back(w);
                end else begin
                    for (int i = 0; i + 2 < fill; i++) begin
                        w = '{ch: line_buf[i][6:0], last: (i + 3 == fill), status: STATUS_DATA};
                        pending_words.push_back(w);
                    end
                end
                fill = 0;
            end else if (b >= SPACE_CODE && fill < LINE_CAP) begin
                line_buf[fill] = b;
                fill++;
            end
        endfunction

        function void check_word(logic [6:0] ch, logic last, logic [1:0] status);
            line_word_t w;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word ch=%h last=%b status=%0d",
                         $time, ch, last, status);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (ch !== w.ch) begin
                $display("%0t: line_char expected %h actual %h", $time, w.ch, ch);
                errors++;
            end
            if (last !== w.last) begin
                $display("%0t: last_of_line expected %b actual %b", $time, w.last, last);
                errors++;
            end
            if (status !== w.status) begin
                $display("%0t: line_status expected %0d actual %0d", $time, w.status, status);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [6:0] m_line_char;
    logic       m_last_of_line;
    logic [1:0] m_line_status;

    line_checksum_board board;
    logic [7:0]         frame_body [$];
    int unsigned        kept_bytes;
    int unsigned        cycle_count;
    bit                 hold_off_req;
    bit                 hold_off_done;

    meter_line_deframer_checksum_check DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_char   (m_line_char),
        .m_last_of_line(m_last_of_line),
        .m_line_status (m_line_status)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] ctrl_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 30));
        return (r >= CR_CODE) ? r + 8'd1 : r;
    endfunction

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(8'h20, 8'hFF));
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_rx_byte(b);
        if (b == CR_CODE || b >= SPACE_CODE) kept_bytes++;
        @(negedge aclk);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(printable_byte());
    endtask

    // frame_body, tail (space, checksum) unless NO_TAIL, spill bytes, then CR
    task automatic send_frame(input frame_fault_t fault, input int ctrl_pct,
                              input int spill, input bit quiet);
        logic [5:0] sum;
        logic [7:0] tail_space;
        logic [7:0] tail_sum;
        logic [7:0] line_bytes [$];
        sum = '0;
        foreach (frame_body[i]) sum += frame_body[i][5:0];
        tail_space = SPACE_CODE;
        tail_sum   = {2'b00, sum} + SPACE_CODE;
        case (fault)
            FRAME_BAD_SUM: begin
                tail_sum = tail_sum ^ 8'($urandom_range(1, 31));
            end
            FRAME_NO_SPACE: begin
                tail_space = 8'($urandom_range(8'h21, 8'hFF));
            end
            FRAME_HIGH_SUM: begin
                tail_sum = tail_sum | 8'h80;
            end
            default: begin
            end
        endcase
        line_bytes = frame_body;
        if (fault != FRAME_NO_TAIL) begin
            line_bytes.push_back(tail_space);
            line_bytes.push_back(tail_sum);
        end
        repeat (spill) line_bytes.push_back(printable_byte());
        line_bytes.push_back(CR_CODE);
        foreach (line_bytes[i]) begin
            if ($urandom_range(0, 99) < ctrl_pct) send_byte(ctrl_byte(), quiet);
            send_byte(line_bytes[i], quiet);
        end
    endtask

    // scoreboard check on every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_word(m_line_char, m_last_of_line, m_line_status);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, long ready stretches, one long hold-off
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(40, 150)) @(negedge aclk);
            end else begin
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    initial begin
        int r;
        int len;
        board         = new;
        kept_bytes    = 0;
        cycle_count   = 0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_rx_byte     = 8'h00;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short lines, control bytes, empty good line
        send_byte(CR_CODE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(CR_CODE, 1'b0);
        frame_body.delete();
        send_frame(FRAME_GOOD, 0, 0, 1'b1);
        frame_body = '{8'h41, 8'h5A};
        send_frame(FRAME_GOOD, 0, 0, 1'b0);
        // high bytes and field extremes
        frame_body = '{8'h20, 8'h7F, 8'hFF, 8'h80};
        send_frame(FRAME_GOOD, 0, 0, 1'b0);
        frame_body = '{8'h4B};
        send_frame(FRAME_BAD_SUM, 0, 0, 1'b0);
        send_frame(FRAME_NO_SPACE, 0, 0, 1'b0);
        send_frame(FRAME_HIGH_SUM, 0, 0, 1'b0);
        send_frame(FRAME_NO_TAIL, 0, 0, 1'b0);
        fill_body(5);
        send_frame(FRAME_GOOD, 50, 0, 1'b0);
        // full store: tail in the last two slots, overflow dropped
        fill_body(LINE_CAP - 2);
        send_frame(FRAME_GOOD, 0, 5, 1'b1);
        fill_body(LINE_CAP - 1);
        send_frame(FRAME_GOOD, 0, 0, 1'b0);

        hold_off_req = 1'b1;
        kept_bytes   = 0;
        while (kept_bytes < RANDOM_BYTES) begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, LINE_CAP)
                                               : $urandom_range(0, 16);
            if (r < 70) begin
                fill_body(len);
                send_frame(FRAME_GOOD, 5, (len > LINE_CAP - 2) ? 0 : $urandom_range(0, 1) * 3,
                           $urandom_range(0, 4) == 0);
            end else if (r < 85) begin
                fill_body(len);
                send_frame(frame_fault_t'($urandom_range(FRAME_BAD_SUM, FRAME_NO_TAIL)), 5, 0,
                           $urandom_range(0, 4) == 0);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_byte(CR_CODE, 1'b0);
            end
        end
        send_byte(CR_CODE, 1'b0);
        s_valid <= 1'b0;

        while (board.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
